// ----- rtl/core/ice_pkg.sv -----
`default_nettype none
package ice_pkg;

    // Mode codes.
    localparam logic [1:0] OP_BODY_BODY   = 2'd0;
    localparam logic [1:0] OP_A_STATIC    = 2'd1;
    localparam logic [1:0] OP_B_STATIC    = 2'd2;
    localparam logic [1:0] OP_NONE        = 2'd3;

    // Restoring divider layout: quotient bits, bits retired per stage.
    localparam int QUO_BITS     = 48;
    localparam int DIV_STEP     = 4;
    localparam int DIV_STAGES   = QUO_BITS / DIV_STEP;

    localparam logic [47:0] ENERGY_MAX = {48{1'b1}};

    // Per-item flags that ride along the pipeline.
    typedef struct packed {
        logic zero;
        logic dep;
    } t_flags;

endpackage
`default_nettype wire

// ----- rtl/core/inelastic_collision_energy_core.sv -----
// Inelastic contact energy core.
//
// Input channel: i_valid / o_stall with one port per field (mode, two
// velocity vectors, two masses, contact normal). A transaction is taken at
// a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carrying o_energy and o_departing. A
// transaction completes at a rising edge with o_valid high and i_stall low.
//
// Throughput is one transaction per cycle while the receiver does not
// stall. The stages, in order: the dot products, the squaring and mass
// products, the saturation check, the restoring divider (four quotient
// bits per stage) and one output register.
//
// Reset (synchronous, active low) clears every valid bit; the pipeline
// then holds no transactions. When the receiver stalls a waiting result,
// the whole pipeline freezes and o_stall rises; nothing is lost or
// repeated, and bubbles keep flowing while the output slot is empty.
`default_nettype none
module inelastic_collision_energy_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [1:0]          i_op,
    input  wire  signed [15:0]  i_vel_a_x,
    input  wire  signed [15:0]  i_vel_a_y,
    input  wire  signed [15:0]  i_vel_a_z,
    input  wire  signed [15:0]  i_vel_b_x,
    input  wire  signed [15:0]  i_vel_b_y,
    input  wire  signed [15:0]  i_vel_b_z,
    input  wire  [15:0]         i_mass_a,
    input  wire  [15:0]         i_mass_b,
    input  wire  signed [15:0]  i_norm_x,
    input  wire  signed [15:0]  i_norm_y,
    input  wire  signed [15:0]  i_norm_z,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [47:0]         o_energy,
    output logic                o_departing
);

    localparam int NS = ice_pkg::DIV_STAGES;

    // The pipeline moves when the output slot is empty or being drained.
    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Stage valid bits: 1..7 arithmetic, 8 saturation check.
    logic [8:1] r_v;
    logic [NS:1] r_dv;

    // Stage 1: the six velocity-normal products.
    logic signed [31:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic [1:0]  r_op1, r_op2;
    logic [15:0] r_ma1, r_mb1, r_ma2, r_mb2;

    // Stage 2: projections.
    logic signed [33:0] r_pa, r_pb;
    logic signed [33:0] n_pa, n_pb;

    // Stage 3: relative speed, mass product, divisor and flags.
    logic [33:0] r_d3, n_d3;
    logic [31:0] r_mm3, n_mm3;
    logic [16:0] r_ms3, n_ms3;
    ice_pkg::t_flags r_f3, n_f3;

    // Stage 4: partial squares; stage 5: square.
    logic [33:0] r_hh, r_hl, r_ll;
    logic [31:0] r_mm4, r_mm5;
    logic [16:0] r_ms4, r_ms5, r_ms6, r_ms7;
    ice_pkg::t_flags r_f4, r_f5, r_f6, r_f7;
    logic [67:0] r_sq5, n_sq5;

    // Stage 6: square times mass product, in three slices; stage 7: sum.
    logic [54:0] r_x0, r_x1, r_x2;
    logic [69:0] r_y7, n_y7;
    logic [99:0] n_x;

    // Divider stages; index 0 is the saturation check stage.
    logic [16:0] r_rem [0:NS];
    logic [47:0] r_dvd [0:NS];
    logic [47:0] r_quo [0:NS];
    logic [16:0] r_ms  [0:NS];
    logic        r_sat [0:NS];
    ice_pkg::t_flags r_fd [0:NS];
    logic [16:0] n_rem [1:NS];
    logic [47:0] n_dvd [1:NS];
    logic [47:0] n_quo [1:NS];

    always_comb begin
        n_pa = 34'(r_ax) + 34'(r_ay) + 34'(r_az);
        n_pb = 34'(r_bx) + 34'(r_by) + 34'(r_bz);
    end

    // The static modes reuse the reduced-mass path: m*q^2/2 equals
    // (2m)*q^2 divided by one and scaled like the body-body case.
    always_comb begin
        logic signed [33:0] q;
        q     = '0;
        n_d3  = '0;
        n_mm3 = '0;
        n_ms3 = 17'd1;
        n_f3  = '{zero: 1'b1, dep: 1'b0};
        unique case (r_op2)
            ice_pkg::OP_BODY_BODY: begin
                q     = r_pb - r_pa;
                n_d3  = q;
                n_mm3 = 32'(r_ma2) * 32'(r_mb2);
                n_ms3 = 17'(r_ma2) + 17'(r_mb2);
                n_f3.dep  = r_pa > r_pb;
                n_f3.zero = (r_pa > r_pb) || (n_ms3 == 17'd0);
            end
            ice_pkg::OP_A_STATIC, ice_pkg::OP_B_STATIC: begin
                q     = (r_op2 == ice_pkg::OP_A_STATIC) ? -r_pa : r_pb;
                n_d3  = q;
                n_mm3 = (r_op2 == ice_pkg::OP_A_STATIC) ? {15'd0, r_ma2, 1'b0}
                                                         : {15'd0, r_mb2, 1'b0};
                n_f3.dep  = q[33];
                n_f3.zero = q[33];
            end
            default: begin
                n_f3 = '{zero: 1'b1, dep: 1'b0};
            end
        endcase
    end

    always_comb begin
        n_sq5 = (68'(r_hh) << 34) + (68'(r_hl) << 18) + 68'(r_ll);
        n_x   = 100'(r_x0) + (100'(r_x1) << 23) + (100'(r_x2) << 46);
        n_y7  = n_x[99:30];
    end

    // Restoring division, DIV_STEP quotient bits per stage. The partial
    // remainder stays below the divisor unless the saturation flag is set.
    always_comb begin
        logic [17:0] t;
        logic [16:0] rm;
        logic [47:0] dv, qu;
        t = '0;
        for (int k = 1; k <= NS; k++) begin
            rm = r_rem[k-1];
            dv = r_dvd[k-1];
            qu = r_quo[k-1];
            for (int j = 0; j < ice_pkg::DIV_STEP; j++) begin
                t  = {rm, dv[47]};
                dv = {dv[46:0], 1'b0};
                if (t >= {1'b0, r_ms[k-1]}) begin
                    t  = t - {1'b0, r_ms[k-1]};
                    qu = {qu[46:0], 1'b1};
                end else begin
                    qu = {qu[46:0], 1'b0};
                end
                rm = t[16:0];
            end
            n_rem[k] = rm;
            n_dvd[k] = dv;
            n_quo[k] = qu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_dv    <= '0;
            o_valid <= 1'b0;
        end else if (en) begin
            r_v     <= {r_v[7:1], i_valid};
            r_dv    <= {r_dv[NS-1:1], r_v[8]};
            o_valid <= r_dv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax  <= 32'(i_vel_a_x) * 32'(i_norm_x);
            r_ay  <= 32'(i_vel_a_y) * 32'(i_norm_y);
            r_az  <= 32'(i_vel_a_z) * 32'(i_norm_z);
            r_bx  <= 32'(i_vel_b_x) * 32'(i_norm_x);
            r_by  <= 32'(i_vel_b_y) * 32'(i_norm_y);
            r_bz  <= 32'(i_vel_b_z) * 32'(i_norm_z);
            r_op1 <= i_op;
            r_ma1 <= i_mass_a;
            r_mb1 <= i_mass_b;

            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_op2 <= r_op1;
            r_ma2 <= r_ma1;
            r_mb2 <= r_mb1;

            r_d3  <= n_d3;
            r_mm3 <= n_mm3;
            r_ms3 <= n_ms3;
            r_f3  <= n_f3;

            r_hh  <= 34'(r_d3[33:17]) * 34'(r_d3[33:17]);
            r_hl  <= 34'(r_d3[33:17]) * 34'(r_d3[16:0]);
            r_ll  <= 34'(r_d3[16:0]) * 34'(r_d3[16:0]);
            r_mm4 <= r_mm3;
            r_ms4 <= r_ms3;
            r_f4  <= r_f3;

            r_sq5 <= n_sq5;
            r_mm5 <= r_mm4;
            r_ms5 <= r_ms4;
            r_f5  <= r_f4;

            r_x0  <= 55'(r_sq5[22:0])  * 55'(r_mm5);
            r_x1  <= 55'(r_sq5[45:23]) * 55'(r_mm5);
            r_x2  <= 55'(r_sq5[67:46]) * 55'(r_mm5);
            r_ms6 <= r_ms5;
            r_f6  <= r_f5;

            r_y7  <= n_y7;
            r_ms7 <= r_ms6;
            r_f7  <= r_f6;

            // Quotient overflows 48 bits exactly when the top of the
            // dividend reaches the divisor.
            r_sat[0] <= r_y7[69:48] >= 22'(r_ms7);
            r_rem[0] <= r_y7[64:48];
            r_dvd[0] <= r_y7[47:0];
            r_quo[0] <= '0;
            r_ms[0]  <= r_ms7;
            r_fd[0]  <= r_f7;

            for (int k = 1; k <= NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvd[k] <= n_dvd[k];
                r_quo[k] <= n_quo[k];
                r_ms[k]  <= r_ms[k-1];
                r_sat[k] <= r_sat[k-1];
                r_fd[k]  <= r_fd[k-1];
            end

            o_departing <= r_fd[NS].dep;
            if (r_fd[NS].zero) begin
                o_energy <= '0;
            end else if (r_sat[NS]) begin
                o_energy <= ice_pkg::ENERGY_MAX;
            end else begin
                o_energy <= r_quo[NS];
            end
        end
    end

    // A departing result never carries energy.
    a_dep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_departing |-> o_energy == 48'd0)
        else $error("departing result with nonzero energy");

    // Upstream is held back only while a result waits at the output.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // A stalled result reappears unchanged in the next cycle.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_energy) && $stable(o_departing))
        else $error("stalled result changed");

endmodule
`default_nettype wire
